>>> rtl/core/sqr_pkg.sv
// sqr_pkg: sizes, codes and shared types of the sequence reorder queue
// no dependencies; used by the interfaces, the queue cell and the top level
package sqr_pkg;

   localparam int Depth       = 32;
   localparam int SeqBits     = 16;
   localparam int PayloadBits = 32;
   localparam int CountBits   = $clog2(Depth + 1);
   localparam int FlushBits   = 6;
   localparam int CmpBits     = (CountBits > FlushBits) ? CountBits : FlushBits;
   localparam logic [FlushBits-1:0] FlushReset = FlushBits'(16);

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_NORMAL = 2'd0,
      KIND_IGNORE = 2'd1,
      KIND_FLUSH  = 2'd2,
      KIND_OTHER  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_NONE    = 2'd1,
      STATUS_DROPPED = 2'd2,
      STATUS_AUTO    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_POP
   } cmd_op_type;

   typedef struct packed {
      logic [SeqBits-1:0]     seq;
      logic                   ign;
      logic [PayloadBits-1:0] payload;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cmd_op_type op;
      logic       mark;
      logic       ordered;
      entry_type  item;
   } cmd_type;

endpackage

>>> rtl/core/sqr_if.sv
// sqr_req_if and sqr_rsp_if: valid/ready channels of the reorder queue
// depends on sqr_pkg for field widths
interface sqr_req_if;
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic [1:0]                     kind;
   logic [sqr_pkg::SeqBits-1:0]     sequence_req;
   logic [sqr_pkg::PayloadBits-1:0] payload;

   modport source (output valid, op, kind, sequence_req, payload, input ready);
   modport sink   (input valid, op, kind, sequence_req, payload, output ready);
endinterface

interface sqr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [sqr_pkg::PayloadBits-1:0] out_payload;
   logic [sqr_pkg::SeqBits-1:0]     out_sequence;
   logic                           out_unordered;

   modport source (output valid, status, out_payload, out_sequence, out_unordered,
                   input ready);
   modport sink   (input valid, status, out_payload, out_sequence, out_unordered,
                   output ready);
endinterface

>>> rtl/core/sqr_cell.sv
// sqr_cell: one queue slot; shifts toward the front on pop, toward the back on insert
// depends on sqr_pkg; instantiated in a row by sequence_reorder_queue
module sqr_cell (
   input  logic                clock,
   input  sqr_pkg::cmd_type    cmd,
   input  logic                occupied,
   input  logic                prev_after,
   input  sqr_pkg::entry_type  left,
   input  sqr_pkg::entry_type  right,
   output logic                after,
   output logic                gt,
   output sqr_pkg::entry_type  entry
);

   sqr_pkg::entry_type entry_ff;
   sqr_pkg::entry_type entry_in;

   // new item goes in front of the first normal entry with a greater sequence
   assign gt    = occupied & ~entry_ff.ign & cmd.ordered & (cmd.item.seq < entry_ff.seq);
   assign after = prev_after | gt | ~occupied;
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         sqr_pkg::CMD_HOLD: begin
            entry_in = entry_ff;
         end
         sqr_pkg::CMD_INSERT: begin
            if (prev_after) begin
               entry_in = left;
            end else if (after) begin
               entry_in = cmd.item;
            end
         end
         sqr_pkg::CMD_POP: begin
            entry_in = right;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
      if (cmd.mark) begin
         entry_in.ign = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> rtl/core/sequence_reorder_queue.sv
// sequence_reorder_queue: reorder buffer for sequence-numbered items, built as a row of cells
// depends on sqr_pkg, sqr_req_if, sqr_rsp_if and sqr_cell
//
//   channel  direction  handshake           carries
//   req_chan in         valid/ready         op, kind, sequence_req, payload
//   rsp_chan out        valid/ready         status, out_payload, out_sequence, out_unordered
//   csr_*    in         csr_wr_en           auto_flush_length (6 bits)
//
// each transfer first registers the request; then every cell of the row shifts,
// inserts or marks at once and the result is registered
// one request at a time; a new request is taken while a result still waits
// a waiting result holds the row until it is taken
// reset clears the count, the expected sequence and both channels; flush length goes to 16
module sequence_reorder_queue (
   input  logic                             clock,
   input  logic                             reset,
   sqr_req_if.sink                          req_chan,
   sqr_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [sqr_pkg::FlushBits-1:0]    csr_wr_data
);

   localparam int Depth = sqr_pkg::Depth;

   logic                            busy_ff, busy_in;
   logic                            op_ff;
   logic [1:0]                      kind_ff;
   logic [sqr_pkg::SeqBits-1:0]     seq_ff;
   logic [sqr_pkg::PayloadBits-1:0] pay_ff;

   logic [sqr_pkg::CountBits-1:0]   count_ff, count_in;
   logic [sqr_pkg::SeqBits-1:0]     last_ff, last_in;
   logic                            known_ff, known_in;
   logic [sqr_pkg::SeqBits-1:0]     back_seq_ff, back_seq_in;
   logic                            back_ign_ff, back_ign_in;
   logic [sqr_pkg::FlushBits-1:0]   flush_len_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      status_ff, status_in;
   logic [sqr_pkg::PayloadBits-1:0] out_pay_ff, out_pay_in;
   logic [sqr_pkg::SeqBits-1:0]     out_seq_ff, out_seq_in;
   logic                            out_unord_ff, out_unord_in;

   sqr_pkg::cmd_type                cmd;
   sqr_pkg::entry_type              entries [Depth];
   logic [Depth-1:0]                after_v;
   logic [Depth-1:0]                gt_v;
   logic                            fire;
   logic [sqr_pkg::SeqBits-1:0]     expect_seq;
   logic                            is_normal;

   assign req_chan.ready = ~busy_ff & ~reset;
   assign fire           = busy_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign busy_in        = (req_chan.valid & ~busy_ff) | (busy_ff & ~fire);
   assign expect_seq     = known_ff ? (last_ff + 1'b1) : '0;
   assign is_normal      = (kind_ff != sqr_pkg::KIND_IGNORE) && (kind_ff != sqr_pkg::KIND_FLUSH);

   // the row of cells
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic               prev_after;
      sqr_pkg::entry_type left;
      sqr_pkg::entry_type right;
      if (i == 0) begin : g_head
         assign prev_after = 1'b0;
         assign left       = '0;
      end else begin : g_body
         assign prev_after = after_v[i-1];
         assign left       = entries[i-1];
      end
      if (i == Depth - 1) begin : g_tail
         assign right = '0;
      end else begin : g_mid
         assign right = entries[i+1];
      end
      sqr_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (sqr_pkg::CountBits'(i) < count_ff),
         .prev_after (prev_after),
         .left       (left),
         .right      (right),
         .after      (after_v[i]),
         .gt         (gt_v[i]),
         .entry      (entries[i])
      );
   end

   always_comb begin
      cmd          = '0;
      cmd.op       = sqr_pkg::CMD_HOLD;
      cmd.ordered  = is_normal;
      cmd.item.seq = is_normal ? seq_ff : '0;
      cmd.item.ign = ~is_normal;
      cmd.item.payload = pay_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      known_in     = known_ff;
      back_seq_in  = back_seq_ff;
      back_ign_in  = back_ign_ff;
      status_in    = status_ff;
      out_pay_in   = out_pay_ff;
      out_seq_in   = out_seq_ff;
      out_unord_in = out_unord_ff;
      if (fire) begin
         status_in    = sqr_pkg::STATUS_DONE;
         out_pay_in   = '0;
         out_seq_in   = '0;
         out_unord_in = 1'b0;
         if (op_ff == sqr_pkg::OP_ENQUEUE) begin
            if (count_ff == sqr_pkg::CountBits'(Depth)) begin
               status_in = sqr_pkg::STATUS_DROPPED;
            end else begin
               cmd.op   = sqr_pkg::CMD_INSERT;
               cmd.mark = (kind_ff == sqr_pkg::KIND_FLUSH);
               count_in = count_ff + 1'b1;
               // no greater normal entry: the item lands at the back
               if (~|gt_v) begin
                  back_seq_in = cmd.item.seq;
                  back_ign_in = cmd.item.ign;
               end
               if (kind_ff == sqr_pkg::KIND_FLUSH) begin
                  back_ign_in = 1'b1;
                  last_in     = '0;
                  known_in    = 1'b0;
               end
            end
         end else begin
            priority if (count_ff == '0) begin
               status_in = sqr_pkg::STATUS_NONE;
            end else if (entries[0].ign) begin
               cmd.op       = sqr_pkg::CMD_POP;
               count_in     = count_ff - 1'b1;
               out_pay_in   = entries[0].payload;
               out_unord_in = 1'b1;
            end else if (entries[0].seq == expect_seq) begin
               cmd.op     = sqr_pkg::CMD_POP;
               count_in   = count_ff - 1'b1;
               out_pay_in = entries[0].payload;
               out_seq_in = entries[0].seq;
               last_in    = expect_seq;
               known_in   = 1'b1;
            end else if (sqr_pkg::CmpBits'(count_ff) >= sqr_pkg::CmpBits'(flush_len_ff)) begin
               cmd.op       = sqr_pkg::CMD_POP;
               cmd.mark     = 1'b1;
               count_in     = count_ff - 1'b1;
               status_in    = sqr_pkg::STATUS_AUTO;
               out_pay_in   = entries[0].payload;
               out_unord_in = 1'b1;
               last_in      = back_ign_ff ? '0 : back_seq_ff;
               known_in     = ~back_ign_ff;
               back_ign_in  = 1'b1;
            end else begin
               status_in = sqr_pkg::STATUS_NONE;
            end
         end
      end
   end

   assign rsp_valid_in = fire | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         last_ff      <= '0;
         known_ff     <= 1'b0;
         flush_len_ff <= sqr_pkg::FlushReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         known_ff     <= known_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            flush_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid & ~busy_ff) begin
         op_ff   <= req_chan.op;
         kind_ff <= req_chan.kind;
         seq_ff  <= req_chan.sequence_req;
         pay_ff  <= req_chan.payload;
      end
      back_seq_ff  <= back_seq_in;
      back_ign_ff  <= back_ign_in;
      status_ff    <= status_in;
      out_pay_ff   <= out_pay_in;
      out_seq_ff   <= out_seq_in;
      out_unord_ff <= out_unord_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.out_payload   = out_pay_ff;
   assign rsp_chan.out_sequence  = out_seq_ff;
   assign rsp_chan.out_unordered = out_unord_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= sqr_pkg::CountBits'(Depth))
      else $error("queue count beyond depth");

   a_hold_when_stalled : assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff) && $stable(known_ff))
      else $error("queue state changed without a transfer");

   a_auto_unordered : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == sqr_pkg::STATUS_AUTO |-> out_unord_ff)
      else $error("auto-flush release not marked unordered");

endmodule
